FILE: hw/rtl/pmlm_pkg.sv
// Shared types and constants for the pooled multi-list manager.
package pmlm_pkg;

   // Fixed field widths of the request and response beats.
   localparam int OPCODE_W  = 3;
   localparam int NODE_ID_W = 12;
   localparam int LIST_ID_W = 9;
   localparam int VALUE_W   = 32;

   // Operation codes carried in the request opcode field.
   localparam logic [OPCODE_W-1:0] OP_QUERY    = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_DELETE   = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_INS_HEAD = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_INS_TAIL = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_UPDATE   = 3'd4;

   // Reset value of the list count register.
   localparam logic [LIST_ID_W-1:0] LISTS_IN_USE_RESET = 9'd511;

   // Request beat.
   typedef struct packed {
      logic [OPCODE_W-1:0]         opcode;
      logic [NODE_ID_W-1:0]        node_id;
      logic [LIST_ID_W-1:0]        list_id;
      logic signed [VALUE_W-1:0]   new_value;
   } req_type;

   // Response beat.
   typedef struct packed {
      logic                        status;
      logic                        prev_present;
      logic signed [VALUE_W-1:0]   prev_value;
      logic signed [VALUE_W-1:0]   node_value;
      logic                        next_present;
      logic signed [VALUE_W-1:0]   next_value;
      logic [NODE_ID_W-1:0]        new_node;
   } rsp_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_CHECK,
      S_QPREV,
      S_QNEXT,
      S_DUNLINK,
      S_ILINK,
      S_DONE
   } state_type;

endpackage

FILE: hw/rtl/pooled_multi_list_manager.sv
// Pooled multi-list manager: doubly linked lists in one shared node pool, run by a sequencer.
//
// Many doubly linked lists share one pool of POOL_DEPTH nodes held in block RAM; nodes are
// numbered from 1 in allocation order and a new node's value starts as its number. Each request
// beat is one operation, run by a small sequencer over single-port-read RAMs (node values, prev
// links, next links, owner and live bit, and list head/tail), and gives exactly one response
// beat. After the accept state S_IDLE, every request passes S_CHECK; a query then runs S_QPREV
// and S_QNEXT, a delete S_DUNLINK and an insert into a non-empty list S_ILINK, before S_DONE
// loads the response register: the value RAM has one read port, so the node, its predecessor
// and its successor are read one after another, and a delete or linking insert needs a second
// write to a link RAM. A new request is taken in the cycle after the response is loaded, while
// that response may still wait in the output register; a new request is thus never taken before
// the last one's response is loaded. After reset a clearing pass writes every list head/tail
// entry to empty, one per cycle; requests are stalled meanwhile and the list count register
// may be written. Bad node or list numbers, dead nodes, a full pool and unknown opcodes change
// nothing and return status 1.
module pooled_multi_list_manager
   import pmlm_pkg::*;
   #(
   parameter int POOL_DEPTH = 4096,
   parameter int MAX_LISTS  = 512
   )
   (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_wr_en,
   input  logic [LIST_ID_W-1:0] csr_wr_data
   );

   localparam int NW  = $clog2(POOL_DEPTH);
   localparam int LW  = $clog2(MAX_LISTS);
   localparam int CW  = (NW > NODE_ID_W) ? NW : NODE_ID_W;
   localparam int LXW = (LW > LIST_ID_W) ? LW : LIST_ID_W;
   localparam int MW  = LW + 1;
   localparam logic [NW-1:0] ALLOC_LIMIT = NW'(POOL_DEPTH - 1);
   localparam logic [LW-1:0] CLEAR_LAST  = LW'(MAX_LISTS - 1);

   // Control and payload registers.
   state_type            state_ff, state_in;
   req_type              req_ff, req_in;
   logic [NW-1:0]        p_ff, p_in;
   logic [NW-1:0]        n_ff, n_in;
   logic [LW-1:0]        lst_ff, lst_in;
   rsp_type              wres_ff, wres_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [NW-1:0]        alloc_ff, alloc_in;
   logic [LW-1:0]        clr_ff, clr_in;
   logic [LIST_ID_W-1:0] liu_ff, liu_in;

   // RAM ports.
   logic                 v_we, v_re;
   logic [NW-1:0]        v_wa, v_ra;
   logic [VALUE_W-1:0]   v_wd, v_rd;
   logic                 m_we, m_re;
   logic [NW-1:0]        m_wa, m_ra;
   logic [MW-1:0]        m_wd, m_rd;
   logic                 pr_we, pr_re;
   logic [NW-1:0]        pr_wa, pr_ra, pr_wd, pr_rd;
   logic                 nx_we, nx_re;
   logic [NW-1:0]        nx_wa, nx_ra, nx_wd, nx_rd;
   logic                 l_we, l_re;
   logic [LW-1:0]        l_wa, l_ra;
   logic [2*NW-1:0]      l_wd, l_rd;

   // Decoded numbers of the incoming beat and of the held beat.
   logic [CW-1:0]        in_id_ext, ck_id_ext, nid_ext;
   logic [LXW-1:0]       in_lst_ext, ck_lst_ext;
   logic [NW-1:0]        in_id_addr, ck_id_addr, nid;
   logic [LW-1:0]        in_lst_addr, ck_lst_addr, owner;
   logic                 node_in_range, list_ok, pool_ok, node_ok, live;
   logic [NW-1:0]        l_first, l_last;

   assign in_id_ext   = CW'(req_data.node_id);
   assign in_id_addr  = in_id_ext[NW-1:0];
   assign in_lst_ext  = LXW'(req_data.list_id);
   assign in_lst_addr = in_lst_ext[LW-1:0];
   assign ck_id_ext   = CW'(req_ff.node_id);
   assign ck_id_addr  = ck_id_ext[NW-1:0];
   assign ck_lst_ext  = LXW'(req_ff.list_id);
   assign ck_lst_addr = ck_lst_ext[LW-1:0];
   assign nid         = alloc_ff + 1'b1;
   assign nid_ext     = CW'(nid);

   // Range checks on the held beat; the node bound also keeps it below the pool depth.
   assign node_in_range = (req_ff.node_id != '0) && (ck_id_ext <= CW'(alloc_ff));
   assign list_ok       = (req_ff.list_id != '0) && (req_ff.list_id <= liu_ff) &&
                          (32'(req_ff.list_id) < MAX_LISTS);
   assign pool_ok       = (alloc_ff != ALLOC_LIMIT);
   assign live          = m_rd[0];
   assign owner         = m_rd[MW-1:1];
   assign node_ok       = node_in_range && live;
   assign l_first       = l_rd[2*NW-1:NW];
   assign l_last        = l_rd[NW-1:0];

   // Node and list memories.
   pmlm_ram #(.WIDTH(VALUE_W), .DEPTH(POOL_DEPTH)) u_val_ram (
      .clock(clock), .wr_en(v_we), .wr_addr(v_wa), .wr_data(v_wd),
      .rd_en(v_re), .rd_addr(v_ra), .rd_data(v_rd));

   pmlm_ram #(.WIDTH(MW), .DEPTH(POOL_DEPTH)) u_meta_ram (
      .clock(clock), .wr_en(m_we), .wr_addr(m_wa), .wr_data(m_wd),
      .rd_en(m_re), .rd_addr(m_ra), .rd_data(m_rd));

   pmlm_ram #(.WIDTH(NW), .DEPTH(POOL_DEPTH)) u_prev_ram (
      .clock(clock), .wr_en(pr_we), .wr_addr(pr_wa), .wr_data(pr_wd),
      .rd_en(pr_re), .rd_addr(pr_ra), .rd_data(pr_rd));

   pmlm_ram #(.WIDTH(NW), .DEPTH(POOL_DEPTH)) u_next_ram (
      .clock(clock), .wr_en(nx_we), .wr_addr(nx_wa), .wr_data(nx_wd),
      .rd_en(nx_re), .rd_addr(nx_ra), .rd_data(nx_rd));

   pmlm_ram #(.WIDTH(2 * NW), .DEPTH(MAX_LISTS)) u_list_ram (
      .clock(clock), .wr_en(l_we), .wr_addr(l_wa), .wr_data(l_wd),
      .rd_en(l_re), .rd_addr(l_ra), .rd_data(l_rd));

   // Handshake outputs.
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The list count register takes every write.
   assign liu_in = csr_wr_en ? csr_wr_data : liu_ff;

   // Sequencer: next state, memory control and result assembly.
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      p_in         = p_ff;
      n_in         = n_ff;
      lst_in       = lst_ff;
      wres_in      = wres_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      alloc_in     = alloc_ff;
      clr_in       = clr_ff;

      v_we  = 1'b0; v_wa  = '0; v_wd  = '0; v_re  = 1'b0; v_ra  = in_id_addr;
      m_we  = 1'b0; m_wa  = '0; m_wd  = '0; m_re  = 1'b0; m_ra  = in_id_addr;
      pr_we = 1'b0; pr_wa = '0; pr_wd = '0; pr_re = 1'b0; pr_ra = in_id_addr;
      nx_we = 1'b0; nx_wa = '0; nx_wd = '0; nx_re = 1'b0; nx_ra = in_id_addr;
      l_we  = 1'b0; l_wa  = '0; l_wd  = '0; l_re  = 1'b0; l_ra  = in_lst_addr;

      case (state_ff)
         S_CLEAR: begin
            // Empty one list entry per cycle.
            l_we = 1'b1;
            l_wa = clr_ff;
            if (clr_ff == CLEAR_LAST) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end

         S_IDLE: begin
            // Take a beat and read its node record and list entry at once.
            if (req_valid) begin
               req_in  = req_data;
               lst_in  = in_lst_addr;
               v_re    = 1'b1;
               m_re    = 1'b1;
               pr_re   = 1'b1;
               nx_re   = 1'b1;
               l_re    = 1'b1;
               wres_in = '0;
               wres_in.status = 1'b1;
               state_in = S_CHECK;
            end
         end

         S_CHECK: begin
            state_in = S_DONE;
            case (req_ff.opcode)
               OP_QUERY: begin
                  if (node_ok) begin
                     wres_in.status     = 1'b0;
                     wres_in.node_value = v_rd;
                     p_in  = pr_rd;
                     n_in  = nx_rd;
                     v_re  = 1'b1;
                     v_ra  = pr_rd;
                     state_in = S_QPREV;
                  end
               end
               OP_DELETE: begin
                  // Clear the node's own links and live bit, then fetch its list entry.
                  if (node_ok) begin
                     wres_in.status = 1'b0;
                     p_in   = pr_rd;
                     n_in   = nx_rd;
                     lst_in = owner;
                     pr_we  = 1'b1; pr_wa = ck_id_addr;
                     nx_we  = 1'b1; nx_wa = ck_id_addr;
                     m_we   = 1'b1; m_wa  = ck_id_addr; m_wd = {owner, 1'b0};
                     l_re   = 1'b1; l_ra  = owner;
                     state_in = S_DUNLINK;
                  end
               end
               OP_INS_HEAD, OP_INS_TAIL: begin
                  // Allocate the next node and hook it into the list entry.
                  if (list_ok && pool_ok) begin
                     alloc_in = nid;
                     wres_in.status   = 1'b0;
                     wres_in.new_node = nid_ext[NODE_ID_W-1:0];
                     v_we  = 1'b1; v_wa  = nid; v_wd = VALUE_W'(nid);
                     m_we  = 1'b1; m_wa  = nid; m_wd = {ck_lst_addr, 1'b1};
                     pr_we = 1'b1; pr_wa = nid;
                     nx_we = 1'b1; nx_wa = nid;
                     l_we  = 1'b1; l_wa  = ck_lst_addr;
                     if (l_first == '0) begin
                        l_wd = {nid, nid};
                     end else if (req_ff.opcode == OP_INS_HEAD) begin
                        nx_wd = l_first;
                        l_wd  = {nid, l_last};
                        p_in  = l_first;
                        state_in = S_ILINK;
                     end else begin
                        pr_wd = l_last;
                        l_wd  = {l_first, nid};
                        p_in  = l_last;
                        state_in = S_ILINK;
                     end
                  end
               end
               OP_UPDATE: begin
                  if (node_ok) begin
                     wres_in.status = 1'b0;
                     v_we = 1'b1;
                     v_wa = ck_id_addr;
                     v_wd = req_ff.new_value;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end

         S_QPREV: begin
            // Predecessor value is out; read the successor next.
            if (p_ff != '0) begin
               wres_in.prev_present = 1'b1;
               wres_in.prev_value   = v_rd;
            end
            v_re = 1'b1;
            v_ra = n_ff;
            state_in = S_QNEXT;
         end

         S_QNEXT: begin
            if (n_ff != '0) begin
               wres_in.next_present = 1'b1;
               wres_in.next_value   = v_rd;
            end
            state_in = S_DONE;
         end

         S_DUNLINK: begin
            // Join the neighbors, or move the list's head or tail.
            l_we = 1'b1;
            l_wa = lst_ff;
            l_wd = {((p_ff == '0) ? n_ff : l_first), ((n_ff == '0) ? p_ff : l_last)};
            nx_we = (p_ff != '0); nx_wa = p_ff; nx_wd = n_ff;
            pr_we = (n_ff != '0); pr_wa = n_ff; pr_wd = p_ff;
            state_in = S_DONE;
         end

         S_ILINK: begin
            // Point the old head back, or the old tail forward, at the new node.
            if (req_ff.opcode == OP_INS_HEAD) begin
               pr_we = 1'b1; pr_wa = p_ff; pr_wd = alloc_ff;
            end else begin
               nx_we = 1'b1; nx_wa = p_ff; nx_wd = alloc_ff;
            end
            state_in = S_DONE;
         end

         S_DONE: begin
            // Load the output register once it is free.
            if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_in       = wres_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
         alloc_ff     <= '0;
         clr_ff       <= '0;
         liu_ff       <= LISTS_IN_USE_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         alloc_ff     <= alloc_in;
         clr_ff       <= clr_in;
         liu_ff       <= liu_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      p_ff    <= p_in;
      n_ff    <= n_in;
      lst_ff  <= lst_in;
      wres_ff <= wres_in;
      rsp_ff  <= rsp_in;
   end

   // The allocation count only ever steps up by one.
   a_alloc_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (alloc_ff != $past(alloc_ff))) |-> (alloc_ff == $past(alloc_ff) + 1'b1))
      else $error("node allocation count moved by more than one");

   // The linking step of an insert follows the allocation of its node.
   a_ilink_alloc: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ILINK) |-> (alloc_ff == $past(alloc_ff) + 1'b1))
      else $error("insert linking without a fresh node");

   // The clearing pass covers every list entry before requests are taken.
   a_clear_done: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_IDLE) && ($past(state_ff) == S_CLEAR)) |-> ($past(clr_ff) == CLEAR_LAST))
      else $error("clearing pass ended early");

   // A new node number is only reported on a successful operation.
   a_new_node_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.new_node != '0)) |-> (rsp_ff.status == 1'b0))
      else $error("new node reported on an ignored operation");

endmodule

FILE: hw/rtl/pmlm_ram.sv
// Generic single write port, single read port RAM with registered read data.
module pmlm_ram
   #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
   )
   (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
   );

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port; data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sim/pmlm_monitor.sv
`timescale 1ns / 100ps
// Monitor that predicts every response beat of the pooled multi-list manager and checks it.
module pmlm_monitor
   import pmlm_pkg::*;
   #(
   parameter int POOL_DEPTH = 4096,
   parameter int MAX_LISTS  = 512
   )
   (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  req_type              req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  rsp_type              rsp_data,
   input  logic                 csr_wr_en,
   input  logic [LIST_ID_W-1:0] csr_wr_data,
   output int                   pending,
   output int                   nodes_made,
   output int                   fail_count
   );

   // Shadow copy of the node pool and the list heads and tails.
   logic signed [VALUE_W-1:0] value_mem [POOL_DEPTH];
   logic [NODE_ID_W-1:0]      prev_mem  [POOL_DEPTH];
   logic [NODE_ID_W-1:0]      next_mem  [POOL_DEPTH];
   logic [LIST_ID_W-1:0]      owner_mem [POOL_DEPTH];
   logic                      live_mem  [POOL_DEPTH];
   logic [NODE_ID_W-1:0]      head_mem  [MAX_LISTS];
   logic [NODE_ID_W-1:0]      tail_mem  [MAX_LISTS];
   int                        alloc_count;
   logic [LIST_ID_W-1:0]      list_limit;

   // Responses still owed by the block, oldest first.
   rsp_type awaited_rsp [$];
   int      mismatches = 0;

   // A node can be touched only if it was allocated and has not been unlinked.
   function automatic bit node_alive(input logic [NODE_ID_W-1:0] id);
      return id != '0 && int'(id) <= alloc_count && live_mem[id] == 1'b1;
   endfunction

   // Apply one request beat to the shadow pool and return the response it must produce.
   function automatic rsp_type apply_request(input req_type beat);
      rsp_type              result;
      logic [NODE_ID_W-1:0] id;
      logic [NODE_ID_W-1:0] p;
      logic [NODE_ID_W-1:0] n;
      logic [NODE_ID_W-1:0] fresh;
      logic [LIST_ID_W-1:0] lst;
      result = '0;
      result.status = 1'b1;
      id = beat.node_id;
      lst = beat.list_id;
      case (beat.opcode)
         OP_QUERY: begin
            if (node_alive(id)) begin
               p = prev_mem[id];
               n = next_mem[id];
               result.status = 1'b0;
               result.node_value = value_mem[id];
               if (p != '0) begin
                  result.prev_present = 1'b1;
                  result.prev_value = value_mem[p];
               end
               if (n != '0) begin
                  result.next_present = 1'b1;
                  result.next_value = value_mem[n];
               end
            end
         end
         OP_DELETE: begin
            if (node_alive(id)) begin
               p = prev_mem[id];
               n = next_mem[id];
               if (p == '0) head_mem[owner_mem[id]] = n;
               else next_mem[p] = n;
               if (n == '0) tail_mem[owner_mem[id]] = p;
               else prev_mem[n] = p;
               prev_mem[id] = '0;
               next_mem[id] = '0;
               live_mem[id] = 1'b0;
               result.status = 1'b0;
            end
         end
         OP_INS_HEAD, OP_INS_TAIL: begin
            if (lst != '0 && lst <= list_limit && int'(lst) < MAX_LISTS
                && alloc_count + 1 < POOL_DEPTH) begin
               alloc_count++;
               fresh = alloc_count[NODE_ID_W-1:0];
               value_mem[fresh] = alloc_count;
               owner_mem[fresh] = lst;
               live_mem[fresh] = 1'b1;
               prev_mem[fresh] = '0;
               next_mem[fresh] = '0;
               // An empty list takes the node as both ends; otherwise link at one end.
               if (head_mem[lst] == '0) begin
                  head_mem[lst] = fresh;
                  tail_mem[lst] = fresh;
               end else if (beat.opcode == OP_INS_HEAD) begin
                  next_mem[fresh] = head_mem[lst];
                  prev_mem[head_mem[lst]] = fresh;
                  head_mem[lst] = fresh;
               end else begin
                  prev_mem[fresh] = tail_mem[lst];
                  next_mem[tail_mem[lst]] = fresh;
                  tail_mem[lst] = fresh;
               end
               result.status = 1'b0;
               result.new_node = fresh;
            end
         end
         OP_UPDATE: begin
            if (node_alive(id)) begin
               value_mem[id] = beat.new_value;
               result.status = 1'b0;
            end
         end
         default: begin
         end
      endcase
      return result;
   endfunction

   // Watch both channels and the register port at every edge.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < MAX_LISTS; i++) begin
            head_mem[i] = '0;
            tail_mem[i] = '0;
         end
         alloc_count = 0;
         list_limit = LISTS_IN_USE_RESET;
         awaited_rsp.delete();
      end else begin
         if (csr_wr_en) list_limit = csr_wr_data;

         // A response beat must match the oldest outstanding prediction.
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsp.size() == 0) begin
               if (mismatches < 10) $display("unexpected response beat %h", rsp_data);
               mismatches++;
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_data.status !== want.status
                   || rsp_data.prev_present !== want.prev_present
                   || rsp_data.prev_value !== want.prev_value
                   || rsp_data.node_value !== want.node_value
                   || rsp_data.next_present !== want.next_present
                   || rsp_data.next_value !== want.next_value
                   || rsp_data.new_node !== want.new_node) begin
                  if (mismatches < 10) begin
                     $display("mismatch expected: st %b prev %b/%h node %h next %b/%h new %h",
                              want.status, want.prev_present, want.prev_value,
                              want.node_value, want.next_present, want.next_value,
                              want.new_node);
                     $display("mismatch actual:   st %b prev %b/%h node %h next %b/%h new %h",
                              rsp_data.status, rsp_data.prev_present, rsp_data.prev_value,
                              rsp_data.node_value, rsp_data.next_present,
                              rsp_data.next_value, rsp_data.new_node);
                  end
                  mismatches++;
               end
            end
         end

         // A request beat is predicted as soon as it is taken.
         if (req_valid && !req_stall) awaited_rsp.push_back(apply_request(req_data));
      end
      pending <= awaited_rsp.size();
      nodes_made <= alloc_count;
      fail_count <= mismatches;
   end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// Stimulus and verdict for the pooled multi-list manager, with the monitor beside the block.
module testbench;
   import pmlm_pkg::*;

   localparam int POOL        = 4096;
   localparam int LISTS       = 512;
   localparam int QUIET_LIMIT = 4000;
   localparam int PHASE_BEATS = 135;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b1;
   rsp_type              rsp_data;
   logic                 csr_wr_en;
   logic [LIST_ID_W-1:0] csr_wr_data;

   int   pending;
   int   nodes_made;
   int   fail_count;
   int   tx_idle_pct = 13;
   int   rx_idle_pct = 71;
   int   cur_lists = 511;
   int   quiet_cycles = 0;
   bit   hold_go = 1'b0;
   logic hold_on = 1'b0;

   // List count settings, one per random sub-phase, extremes included.
   int cfg_plan [12] = '{3, 1, 0, 511, 5, 2, 12, 511, 1, 7, 3, 255};

   pooled_multi_list_manager #(.POOL_DEPTH(POOL), .MAX_LISTS(LISTS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   pmlm_monitor #(.POOL_DEPTH(POOL), .MAX_LISTS(LISTS)) monitor_i (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .pending     (pending),
      .nodes_made  (nodes_made),
      .fail_count  (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Receiver: random stalls, plus one long hold-off on request.
   always @(posedge clock) begin
      rsp_stall <= hold_on || ($urandom_range(0, 99) < rx_idle_pct);
   end

   initial begin
      wait (hold_go);
      @(posedge clock);
      hold_on <= 1'b1;
      repeat (300) @(posedge clock);
      hold_on <= 1'b0;
   end

   // Watchdog: give up when neither channel moves a beat for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Offer one request beat, with random idle cycles first, and wait until it is taken.
   task automatic send_beat(input req_type beat);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic issue(input logic [OPCODE_W-1:0] op, input int node, input int lst,
                        input logic [VALUE_W-1:0] value);
      req_type beat;
      beat.opcode = op;
      beat.node_id = node[NODE_ID_W-1:0];
      beat.list_id = lst[LIST_ID_W-1:0];
      beat.new_value = value;
      send_beat(beat);
   endtask

   // Stop offering and wait until every predicted response has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic set_lists(input int value);
      drain_results();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value[LIST_ID_W-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_lists = value;
   endtask

   // Mostly well-formed requests on live nodes and valid lists, with some noise.
   function automatic req_type random_beat();
      req_type beat;
      int      roll;
      int      nm;
      int      lo;
      roll = $urandom_range(0, 99);
      nm = nodes_made;
      if ($urandom_range(0, 3) == 0) begin
         case ($urandom_range(0, 3))
            0: beat.new_value = 32'h8000_0000;
            1: beat.new_value = 32'h7fff_ffff;
            2: beat.new_value = '0;
            default: beat.new_value = '1;
         endcase
      end else begin
         beat.new_value = $urandom;
      end
      if (roll < 8) begin
         beat.opcode = OPCODE_W'($urandom_range(0, 7));
         beat.node_id = NODE_ID_W'($urandom);
         beat.list_id = LIST_ID_W'($urandom);
         return beat;
      end
      roll = $urandom_range(0, 99);
      if (roll < 36) beat.opcode = $urandom_range(0, 1) ? OP_INS_HEAD : OP_INS_TAIL;
      else if (roll < 66) beat.opcode = OP_QUERY;
      else if (roll < 82) beat.opcode = OP_UPDATE;
      else beat.opcode = OP_DELETE;
      // Recent nodes are the ones most likely still live.
      roll = $urandom_range(0, 99);
      if (nm == 0) begin
         beat.node_id = NODE_ID_W'($urandom_range(0, 15));
      end else if (roll < 55) begin
         lo = (nm > 24) ? nm - 24 : 1;
         beat.node_id = NODE_ID_W'($urandom_range(lo, nm));
      end else if (roll < 95) begin
         beat.node_id = NODE_ID_W'($urandom_range(1, nm));
      end else begin
         beat.node_id = NODE_ID_W'(nm + 1);
      end
      if (cur_lists == 0 || $urandom_range(0, 9) == 0) begin
         beat.list_id = LIST_ID_W'($urandom_range(0, 511));
      end else begin
         beat.list_id = LIST_ID_W'($urandom_range(1, cur_lists));
      end
      return beat;
   endfunction

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed beats: bad numbers, both ends of a list, value extremes, deletes.
      issue(OP_QUERY, 1, 0, $urandom);
      issue(OP_DELETE, 0, 0, $urandom);
      issue(OP_UPDATE, 0, 0, 32'h1234_5678);
      issue(OP_INS_HEAD, 0, 0, $urandom);
      issue(OP_INS_TAIL, 0, 511, $urandom);
      issue(OP_INS_HEAD, 0, 511, $urandom);
      issue(OP_INS_TAIL, 4095, 511, $urandom);
      issue(OP_INS_HEAD, 0, 1, $urandom);
      issue(OP_QUERY, 1, 0, $urandom);
      issue(OP_UPDATE, 1, 0, 32'h8000_0000);
      issue(OP_UPDATE, 2, 0, 32'h7fff_ffff);
      issue(OP_UPDATE, 3, 0, 32'hffff_ffff);
      issue(OP_QUERY, 1, 0, $urandom);
      issue(OP_QUERY, 4095, 511, $urandom);
      issue(OP_QUERY, 5, 0, $urandom);
      for (int op = 5; op < 8; op++) issue(op[OPCODE_W-1:0], $urandom, $urandom, $urandom);
      issue(OP_DELETE, 1, 0, $urandom);
      issue(OP_QUERY, 2, 0, $urandom);
      issue(OP_DELETE, 1, 0, $urandom);
      issue(OP_QUERY, 1, 0, $urandom);
      issue(OP_UPDATE, 1, 0, '0);
      issue(OP_DELETE, 3, 0, $urandom);
      issue(OP_DELETE, 2, 0, $urandom);
      issue(OP_INS_HEAD, 0, 511, $urandom);
      issue(OP_QUERY, 4, 0, $urandom);

      // Random beats under three idling patterns, with a new list count per sub-phase.
      for (int mode = 0; mode < 3; mode++) begin
         tx_idle_pct = (mode == 0) ? 13 : (mode == 1) ? 71 : 0;
         rx_idle_pct <= (mode == 0) ? 71 : (mode == 1) ? 13 : 0;
         for (int sub = 0; sub < 4; sub++) begin
            set_lists(cfg_plan[mode * 4 + sub]);
            if (mode == 2 && sub == 0) hold_go = 1'b1;
            repeat (PHASE_BEATS) send_beat(random_beat());
         end
      end

      // Fill the pool, then exercise the full pool and the highest node number.
      set_lists(511);
      while (nodes_made < POOL - 1) begin
         if ($urandom_range(0, 99) < 85)
            issue($urandom_range(0, 1) ? OP_INS_HEAD : OP_INS_TAIL, 0,
                  $urandom_range(1, 511), $urandom);
         else
            send_beat(random_beat());
      end
      drain_results();
      issue(OP_INS_HEAD, 0, 1, $urandom);
      issue(OP_INS_TAIL, 0, 511, $urandom);
      issue(OP_QUERY, 4095, 0, $urandom);
      issue(OP_UPDATE, 4095, 0, 32'h8000_0000);
      issue(OP_QUERY, 4095, 0, $urandom);
      issue(OP_DELETE, 4095, 0, $urandom);
      issue(OP_QUERY, 4094, 0, $urandom);
      issue(OP_QUERY, 4095, 0, $urandom);

      // Let the last responses drain, then give the verdict.
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

FILE: pooled_multi_list_manager.f
hw/rtl/pmlm_pkg.sv
hw/rtl/pmlm_ram.sv
hw/rtl/pooled_multi_list_manager.sv
sim/pmlm_monitor.sv
sim/testbench.sv
